// ----- sv/gre_decapsulator_checksum_macros.svh -----
// Assertion macros for the GRE decapsulator checker
`ifndef GRE_DECAPSULATOR_CHECKSUM_MACROS_SVH
`define GRE_DECAPSULATOR_CHECKSUM_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GDC_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gdc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define GDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gdc assertion failed");

`endif

// ----- sv/gdc_pkg.sv -----
// Types, constants and helpers shared by the GRE decapsulator
`timescale 1ns / 1ps
`default_nettype none

package gdc_pkg;

	localparam int IP_HEADER_BYTES  = 20;
	localparam int MAX_PACKET_BYTES = 65535;

	localparam logic [15:0] IP_HDR_LEN   = 16'(IP_HEADER_BYTES);
	localparam logic [15:0] MAX_PKT_LEN  = 16'(MAX_PACKET_BYTES);
	localparam logic [15:0] PROTO_RESET  = 16'h0800;

	// GRE header byte offsets and header lengths
	localparam logic [15:0] OFS_FLAGS    = 16'd0;
	localparam logic [15:0] OFS_PROTO_HI = 16'd2;
	localparam logic [15:0] OFS_PROTO_LO = 16'd3;
	localparam logic [15:0] OFS_CSUM_HI  = 16'd4;
	localparam logic [15:0] OFS_CSUM_LO  = 16'd5;
	localparam logic [15:0] HDR_LEN_CSUM = 16'd8;
	localparam logic [15:0] HDR_LEN_BASE = 16'd4;

	localparam logic [1:0] VERDICT_OK       = 2'd0;
	localparam logic [1:0] VERDICT_BAD_PROTO = 2'd1;
	localparam logic [1:0] VERDICT_BAD_CSUM = 2'd2;
	localparam logic [1:0] VERDICT_TRUNC    = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} gdc_in_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       byte_present;
		logic       end_of_packet;
		logic [1:0] verdict;
	} gdc_out_t;

	typedef struct packed {
		logic [15:0] byte_position;
		logic [15:0] sum_accumulator;
		logic [15:0] received_checksum;
		logic        checksum_present;
		logic [15:0] protocol_word;
		logic [7:0]  high_byte_hold;
		logic        discard_flag;
	} gdc_state_t;

	// one's-complement 16-bit add with end-around carry
	function automatic logic [15:0] ones_add(input logic [15:0] s, input logic [15:0] w);
		logic [16:0] t;
		t = {1'b0, s} + {1'b0, w};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage

`default_nettype wire

// ----- sv/gre_decapsulator_checksum.sv -----
// Top level: GRE decapsulator with Internet checksum check
// A word accepted on the input is held in the input register; once it may advance, its result
//   is written into the result register, from which it is presented.
// Throughput: one byte per cycle unless the output stalls; an input register and a result register carry the flow.
// Bytes that give no result pass through without taking the output slot.
// Reset (arst_n low) clears packet state and valids, and sets expected_protocol to 0x0800.
`timescale 1ns / 1ps
`default_nettype none

module gre_decapsulator_checksum (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire gdc_pkg::gdc_in_t in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output gdc_pkg::gdc_out_t  out_data,
	input  wire                cfg_we,
	input  wire [15:0]         cfg_wdata
);
	import gdc_pkg::*;

	gdc_in_t    in_s1;
	logic       vld_s1;
	gdc_out_t   out_s2;
	logic       vld_s2;
	gdc_state_t st_q;
	gdc_state_t st_next;
	gdc_out_t   res;
	logic       emit;
	logic       advance;
	logic [15:0] proto_q;

	gdc_step u_step (
		.st                (st_q),
		.word              (in_s1),
		.expected_protocol (proto_q),
		.st_next           (st_next),
		.emit              (emit),
		.res               (res)
	);

	assign advance   = vld_s1 && (!emit || !vld_s2 || out_ready);
	assign in_ready  = !vld_s1 || advance;
	assign out_valid = vld_s2;
	assign out_data  = out_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_q <= PROTO_RESET;
		end else if (cfg_we) begin
			proto_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			st_q   <= '0;
		end else begin
			if (in_valid && in_ready)
				vld_s1 <= 1'b1;
			else if (advance)
				vld_s1 <= 1'b0;

			if (advance && emit)
				vld_s2 <= 1'b1;
			else if (out_ready)
				vld_s2 <= 1'b0;

			if (advance)
				st_q <= st_next;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			in_s1 <= in_data;
		if (advance && emit)
			out_s2 <= res;
	end

endmodule

`default_nettype wire

// ----- sv/gdc_step.sv -----
// Per-byte parse, checksum and result logic of the GRE decapsulator
`timescale 1ns / 1ps
`default_nettype none

module gdc_step (
	input  wire gdc_pkg::gdc_state_t st,
	input  wire gdc_pkg::gdc_in_t    word,
	input  wire [15:0]               expected_protocol,
	output gdc_pkg::gdc_state_t      st_next,
	output logic                     emit,
	output gdc_pkg::gdc_out_t        res
);
	import gdc_pkg::*;

	logic [15:0] k;
	logic [15:0] hdr;
	logic [7:0]  sb;
	logic [1:0]  fin;
	logic        b_last;

	assign k      = st.byte_position - IP_HDR_LEN;
	assign b_last = word.last_byte;

	always_comb begin
		st_next = st;
		emit    = 1'b0;
		res     = '0;
		sb      = word.data_byte;
		hdr     = HDR_LEN_BASE;
		fin     = VERDICT_OK;

		if (st.byte_position >= MAX_PKT_LEN) begin
			if (b_last) begin
				emit        = 1'b1;
				res.verdict = st.discard_flag ? VERDICT_BAD_PROTO : VERDICT_TRUNC;
			end
		end else if (st.byte_position < IP_HDR_LEN) begin
			if (b_last) begin
				emit        = 1'b1;
				res.verdict = VERDICT_TRUNC;
			end
		end else begin
			if (k == OFS_FLAGS)
				st_next.checksum_present = word.data_byte[7];
			hdr = st_next.checksum_present ? HDR_LEN_CSUM : HDR_LEN_BASE;

			if (!st.discard_flag) begin
				if (st_next.checksum_present && (k == OFS_CSUM_HI || k == OFS_CSUM_LO)) begin
					if (k == OFS_CSUM_HI)
						st_next.received_checksum[15:8] = word.data_byte;
					else
						st_next.received_checksum[7:0] = word.data_byte;
					sb = 8'hFF;
				end
				if (!k[0]) begin
					st_next.high_byte_hold = sb;
					if (b_last)
						st_next.sum_accumulator = ones_add(st.sum_accumulator, {sb, 8'h00});
				end else begin
					st_next.sum_accumulator = ones_add(st.sum_accumulator,
						{st.high_byte_hold, sb});
				end
				if (k == OFS_PROTO_HI) begin
					st_next.protocol_word[15:8] = word.data_byte;
				end else if (k == OFS_PROTO_LO) begin
					st_next.protocol_word[7:0] = word.data_byte;
					if ({st.protocol_word[15:8], word.data_byte} != expected_protocol)
						st_next.discard_flag = 1'b1;
				end
			end

			if (st_next.checksum_present &&
			    (~st_next.sum_accumulator != st_next.received_checksum))
				fin = VERDICT_BAD_CSUM;

			if (st_next.discard_flag) begin
				if (b_last) begin
					emit        = 1'b1;
					res.verdict = VERDICT_BAD_PROTO;
				end
			end else if (k < hdr) begin
				if (b_last) begin
					emit        = 1'b1;
					res.verdict = ((k + 16'd1) < hdr) ? VERDICT_TRUNC : fin;
				end
			end else begin
				emit             = 1'b1;
				res.payload_byte = word.data_byte;
				res.byte_present = 1'b1;
				if (b_last)
					res.verdict = fin;
			end
		end

		res.end_of_packet = b_last & emit;

		if (b_last)
			st_next = '0;
		else if (st.byte_position < MAX_PKT_LEN)
			st_next.byte_position = st.byte_position + 16'd1;
	end

endmodule

`default_nettype wire

// ----- sv/gdc_checker.sv -----
// Port-level checker for the GRE decapsulator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "gre_decapsulator_checksum_macros.svh"

module gdc_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   out_valid,
	input wire                   out_ready,
	input wire gdc_pkg::gdc_out_t out_data
);
	import gdc_pkg::*;

	// stalled word holds
	`GDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	// a status-only word always closes the packet
	`GDC_ASSERT(a_status_eop, out_valid && !out_data.byte_present, out_data.end_of_packet)
	// verdict is zero except on the closing word
	`GDC_ASSERT(a_verdict_eop, out_valid && !out_data.end_of_packet,
		out_data.verdict == VERDICT_OK)
	// wrong protocol never carries payload
	`GDC_ASSERT(a_proto_nodata, out_valid && out_data.verdict == VERDICT_BAD_PROTO,
		!out_data.byte_present && out_data.payload_byte == 8'h00)

endmodule

bind gre_decapsulator_checksum gdc_checker u_gdc_checker (.*);

`default_nettype wire

// ----- dv/gre_decapsulator_checksum_tb.sv -----
// Testbench for the GRE decapsulator: random packet traffic checked against a byte-level predictor
`timescale 1ns / 1ps

module gre_decapsulator_checksum_tb;
	import gdc_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 3000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	gdc_in_t     in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	gdc_out_t    out_data;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	gdc_in_t  wire_bytes[$];
	gdc_out_t due_results[$];
	gdc_out_t want;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       errs = 0;
	int       quiet_cycles = 0;

	// predictor state
	logic [15:0] exp_proto = PROTO_RESET;
	logic [15:0] pos_q = '0;
	logic [15:0] sum_q = '0;
	logic [15:0] rx_csum_q = '0;
	logic        csum_on_q = 1'b0;
	logic [15:0] proto_q = '0;
	logic [7:0]  hi_q = '0;
	logic        drop_q = 1'b0;

	gre_decapsulator_checksum dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = 17'(a) + 17'(b);
		return t[15:0] + 16'(t[16]);
	endfunction

	function automatic logic [1:0] csum_verdict();
		if (csum_on_q && ~sum_q != rx_csum_q)
			return VERDICT_BAD_CSUM;
		return VERDICT_OK;
	endfunction

	task automatic decap_step(input gdc_in_t w);
		logic [15:0] k;
		logic [15:0] hdr;
		logic [7:0]  sb;
		logic        emit;
		gdc_out_t    r;
		emit = 1'b0;
		r = '0;
		if (pos_q == MAX_PKT_LEN) begin
			if (w.last_byte) begin
				emit = 1'b1;
				r.verdict = drop_q ? VERDICT_BAD_PROTO : VERDICT_TRUNC;
			end
		end else if (pos_q < IP_HDR_LEN) begin
			if (w.last_byte) begin
				emit = 1'b1;
				r.verdict = VERDICT_TRUNC;
			end
		end else begin
			k = pos_q - IP_HDR_LEN;
			if (k == OFS_FLAGS)
				csum_on_q = w.data_byte[7];
			hdr = csum_on_q ? HDR_LEN_CSUM : HDR_LEN_BASE;
			if (!drop_q) begin
				sb = w.data_byte;
				if (csum_on_q && (k == OFS_CSUM_HI || k == OFS_CSUM_LO)) begin
					if (k == OFS_CSUM_HI)
						rx_csum_q[15:8] = w.data_byte;
					else
						rx_csum_q[7:0] = w.data_byte;
					sb = 8'hFF;
				end
				if (!k[0]) begin
					hi_q = sb;
					if (w.last_byte)
						sum_q = fold_add(sum_q, {sb, 8'h00});
				end else begin
					sum_q = fold_add(sum_q, {hi_q, sb});
				end
				if (k == OFS_PROTO_HI) begin
					proto_q[15:8] = w.data_byte;
				end else if (k == OFS_PROTO_LO) begin
					proto_q[7:0] = w.data_byte;
					if (proto_q != exp_proto)
						drop_q = 1'b1;
				end
			end
			if (drop_q) begin
				if (w.last_byte) begin
					emit = 1'b1;
					r.verdict = VERDICT_BAD_PROTO;
				end
			end else if (k < hdr) begin
				if (w.last_byte) begin
					emit = 1'b1;
					r.verdict = (k + 16'd1 < hdr) ? VERDICT_TRUNC : csum_verdict();
				end
			end else begin
				emit = 1'b1;
				r.payload_byte = w.data_byte;
				r.byte_present = 1'b1;
				if (w.last_byte)
					r.verdict = csum_verdict();
			end
		end
		if (w.last_byte) begin
			pos_q = '0;
			sum_q = '0;
			rx_csum_q = '0;
			csum_on_q = 1'b0;
			proto_q = '0;
			hi_q = '0;
			drop_q = 1'b0;
		end else if (pos_q != MAX_PKT_LEN) begin
			pos_q = pos_q + 16'd1;
		end
		if (emit) begin
			r.end_of_packet = w.last_byte;
			due_results.push_back(r);
		end
	endtask

	// one's-complement sum over GRE header and payload, odd tail padded with zero
	function automatic logic [15:0] gre_word_sum(input logic [7:0] pkt[$]);
		logic [15:0] s;
		logic [7:0]  lo;
		int          i;
		s = '0;
		for (i = IP_HEADER_BYTES; i < pkt.size(); i += 2) begin
			lo = (i + 1 < pkt.size()) ? pkt[i + 1] : 8'h00;
			s = fold_add(s, {pkt[i], lo});
		end
		return s;
	endfunction

	// cut > 0 below the packet size ends the packet early after that many bytes
	task automatic make_packet(input bit csum, input logic [15:0] proto, input int pay_len,
			input bit bad_csum, input int cut);
		logic [7:0]  pkt[$];
		logic [15:0] chk;
		gdc_in_t     w;
		int          n;
		int          i;
		for (i = 0; i < IP_HEADER_BYTES; i++)
			pkt.push_back(8'($urandom));
		pkt.push_back({csum, 7'($urandom)});
		pkt.push_back(8'($urandom));
		pkt.push_back(proto[15:8]);
		pkt.push_back(proto[7:0]);
		if (csum) begin
			pkt.push_back(8'hFF);
			pkt.push_back(8'hFF);
			pkt.push_back(8'($urandom));
			pkt.push_back(8'($urandom));
		end
		for (i = 0; i < pay_len; i++)
			pkt.push_back(8'($urandom));
		if (csum) begin
			chk = ~gre_word_sum(pkt);
			if (bad_csum)
				chk = chk ^ (16'd1 << $urandom_range(15));
			pkt[IP_HEADER_BYTES + 4] = chk[15:8];
			pkt[IP_HEADER_BYTES + 5] = chk[7:0];
		end
		n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
		for (i = 0; i < n; i++) begin
			w.data_byte = pkt[i];
			w.last_byte = (i == n - 1);
			wire_bytes.push_back(w);
		end
	endtask

	task automatic random_traffic(input int min_bytes);
		int      r;
		int      len;
		bit      csum;
		gdc_in_t w;
		while (wire_bytes.size() < min_bytes) begin
			r = $urandom_range(99);
			csum = 1'($urandom_range(1));
			if (r < 68) begin
				make_packet(csum, ($urandom_range(9) == 0) ? 16'($urandom) : exp_proto,
					$urandom_range(14), $urandom_range(5) == 0, 0);
			end else if (r < 88) begin
				make_packet(csum, exp_proto, $urandom_range(6), 1'b0,
					$urandom_range(IP_HEADER_BYTES + (csum ? 8 : 4), 1));
			end else begin
				len = $urandom_range(40, 1);
				for (int i = 0; i < len; i++) begin
					w.data_byte = 8'($urandom);
					w.last_byte = (i == len - 1);
					wire_bytes.push_back(w);
				end
			end
		end
	endtask

	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (wire_bytes.size() != 0 || in_valid || due_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		#1;
	endtask

	task automatic write_protocol(input logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		exp_proto = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		#1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (wire_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= wire_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				decap_step(in_data);
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					errs++;
					$display("%0t: unexpected word: byte %h present %b eop %b verdict %0d",
						$time, out_data.payload_byte, out_data.byte_present,
						out_data.end_of_packet, out_data.verdict);
				end else begin
					want = due_results.pop_front();
					if (out_data.payload_byte !== want.payload_byte
							|| out_data.byte_present !== want.byte_present
							|| out_data.end_of_packet !== want.end_of_packet
							|| out_data.verdict !== want.verdict) begin
						errs++;
						$display("%0t: mismatch: expected byte %h present %b eop %b",
							$time, want.payload_byte, want.byte_present,
							want.end_of_packet, " verdict %0d,", want.verdict,
							" got byte %h present %b eop %b verdict %0d",
							out_data.payload_byte, out_data.byte_present,
							out_data.end_of_packet, out_data.verdict);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		send_idle_pct = 38;
		recv_stall_pct = 47;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		#1;

		// short packets: truncation points, exact header ends, checksum and protocol cases
		make_packet(1'b0, exp_proto, 0, 1'b0, 1);
		make_packet(1'b1, exp_proto, 0, 1'b0, IP_HEADER_BYTES);
		make_packet(1'b0, exp_proto, 0, 1'b0, IP_HEADER_BYTES + 3);
		make_packet(1'b0, exp_proto, 0, 1'b0, 0);
		make_packet(1'b1, exp_proto, 0, 1'b0, IP_HEADER_BYTES + 6);
		make_packet(1'b1, exp_proto, 0, 1'b0, 0);
		make_packet(1'b1, exp_proto, 0, 1'b1, 0);
		make_packet(1'b1, exp_proto, 5, 1'b0, 0);
		make_packet(1'b1, exp_proto, 4, 1'b1, 0);
		make_packet(1'b0, exp_proto, 3, 1'b0, 0);
		make_packet(1'b0, exp_proto ^ 16'h0001, 3, 1'b0, 0);
		make_packet(1'b1, exp_proto ^ 16'h8000, 0, 1'b0, IP_HEADER_BYTES + 4);
		wait_idle();

		write_protocol(16'h0000);
		random_traffic(20);
		wait_idle();

		send_idle_pct = 47;
		recv_stall_pct = 38;
		write_protocol(16'hFFFF);
		random_traffic(20);
		wait_idle();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_protocol(16'($urandom));
		random_traffic(15);
		wait_idle();

		write_protocol(PROTO_RESET);
		random_traffic(15);
		wait_idle();

		if (errs == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/gdc_pkg.sv
sv/gdc_step.sv
sv/gre_decapsulator_checksum.sv
sv/gdc_checker.sv
dv/gre_decapsulator_checksum_tb.sv
